/* src/esr_pkg.sv */
package esr_pkg;

  localparam int DATA_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int RATE_W    = 35;
  localparam int CNT_W     = 5;
  localparam int NODES_DEF = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } esr_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic emit;
  } esr_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } esr_stat_t;

endpackage

/* src/esr_ctrl.sv */
module esr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  esr_pkg::esr_stat_t stat,
  output esr_pkg::esr_cmd_t  cmd
);

  esr_pkg::esr_state_t state;
  esr_pkg::esr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      esr_pkg::ST_IDLE: begin
        if (in_valid) state_next = esr_pkg::ST_MUL;
      end
      esr_pkg::ST_MUL: begin
        state_next = esr_pkg::ST_ACC;
      end
      esr_pkg::ST_ACC: begin
        state_next = stat.last ? esr_pkg::ST_EMIT : esr_pkg::ST_IDLE;
      end
      esr_pkg::ST_EMIT: begin
        // wait for the output register to drain
        if (stat.out_free) state_next = esr_pkg::ST_IDLE;
      end
      default: begin
        state_next = esr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      esr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      esr_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      esr_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
      end
      esr_pkg::ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* src/esr_datapath.sv */
module esr_datapath #(
  parameter int NODES = esr_pkg::NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  esr_pkg::esr_cmd_t                 cmd,
  output esr_pkg::esr_stat_t                stat,
  input  logic signed [esr_pkg::DATA_W-1:0] deriv_x,
  input  logic signed [esr_pkg::DATA_W-1:0] deriv_y,
  input  logic signed [esr_pkg::DATA_W-1:0] deriv_z,
  input  logic signed [esr_pkg::DATA_W-1:0] vel_x,
  input  logic signed [esr_pkg::DATA_W-1:0] vel_y,
  input  logic signed [esr_pkg::DATA_W-1:0] vel_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [esr_pkg::RATE_W-1:0] rate_xx,
  output logic signed [esr_pkg::RATE_W-1:0] rate_yy,
  output logic signed [esr_pkg::RATE_W-1:0] rate_zz,
  output logic signed [esr_pkg::RATE_W-1:0] rate_xy,
  output logic signed [esr_pkg::RATE_W-1:0] rate_xz,
  output logic signed [esr_pkg::RATE_W-1:0] rate_yz
);

  localparam logic [esr_pkg::CNT_W-1:0] LastCount = esr_pkg::CNT_W'(NODES);

  logic signed [esr_pkg::DATA_W-1:0] deriv [3];
  logic signed [esr_pkg::DATA_W-1:0] vel   [3];
  logic signed [esr_pkg::PROD_W-1:0] prod  [9];
  logic signed [esr_pkg::RATE_W-1:0] grad  [9];
  logic [esr_pkg::CNT_W-1:0]         count;
  logic [esr_pkg::CNT_W-1:0]         count_next;
  logic signed [esr_pkg::RATE_W:0]   sum_xy;
  logic signed [esr_pkg::RATE_W:0]   sum_xz;
  logic signed [esr_pkg::RATE_W:0]   sum_yz;

  assign count_next    = count + 1'b1;
  assign stat.last     = (count_next == LastCount);
  assign stat.out_free = !out_valid || !out_stall;

  // shear sums carry one extra bit so they never wrap before the halving
  assign sum_xy = {grad[1][esr_pkg::RATE_W-1], grad[1]} + {grad[3][esr_pkg::RATE_W-1], grad[3]};
  assign sum_xz = {grad[2][esr_pkg::RATE_W-1], grad[2]} + {grad[6][esr_pkg::RATE_W-1], grad[6]};
  assign sum_yz = {grad[5][esr_pkg::RATE_W-1], grad[5]} + {grad[7][esr_pkg::RATE_W-1], grad[7]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      deriv[0] <= deriv_x;
      deriv[1] <= deriv_y;
      deriv[2] <= deriv_z;
      vel[0]   <= vel_x;
      vel[1]   <= vel_y;
      vel[2]   <= vel_z;
    end
    if (cmd.mul) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[3*i+j] <= deriv[i] * vel[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int k = 0; k < 9; k++) grad[k] <= '0;
    end else if (cmd.emit) begin
      count <= '0;
      for (int k = 0; k < 9; k++) grad[k] <= '0;
    end else if (cmd.acc) begin
      count <= count_next;
      for (int k = 0; k < 9; k++) begin
        grad[k] <= grad[k] + esr_pkg::RATE_W'(prod[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rate_xx <= grad[0];
      rate_yy <= grad[4];
      rate_zz <= grad[8];
      rate_xy <= sum_xy[esr_pkg::RATE_W:1];
      rate_xz <= sum_xz[esr_pkg::RATE_W:1];
      rate_yz <= sum_yz[esr_pkg::RATE_W:1];
    end
  end

endmodule

/* src/element_strain_rate_top.sv */
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  deriv_x deriv_y deriv_z vel_x vel_y vel_z
// out      output     out_valid/out_stall  rate_xx rate_yy rate_zz rate_xy rate_xz rate_yz
//
// each node steps through accept, nine parallel 16x16 multiplies, then accumulate
// the last node of an element adds an emit state that loads the output register
// the emit state waits while the previous result still sits stalled at the output
// synchronous reset clears the state machine, node count, accumulators and out_valid
module element_strain_rate_top #(
  parameter int NODES = esr_pkg::NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [esr_pkg::DATA_W-1:0] deriv_x,
  input  logic signed [esr_pkg::DATA_W-1:0] deriv_y,
  input  logic signed [esr_pkg::DATA_W-1:0] deriv_z,
  input  logic signed [esr_pkg::DATA_W-1:0] vel_x,
  input  logic signed [esr_pkg::DATA_W-1:0] vel_y,
  input  logic signed [esr_pkg::DATA_W-1:0] vel_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [esr_pkg::RATE_W-1:0] rate_xx,
  output logic signed [esr_pkg::RATE_W-1:0] rate_yy,
  output logic signed [esr_pkg::RATE_W-1:0] rate_zz,
  output logic signed [esr_pkg::RATE_W-1:0] rate_xy,
  output logic signed [esr_pkg::RATE_W-1:0] rate_xz,
  output logic signed [esr_pkg::RATE_W-1:0] rate_yz
);

  esr_pkg::esr_cmd_t  cmd;
  esr_pkg::esr_stat_t stat;

  esr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  esr_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .deriv_x   (deriv_x),
    .deriv_y   (deriv_y),
    .deriv_z   (deriv_z),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rate_xx   (rate_xx),
    .rate_yy   (rate_yy),
    .rate_zz   (rate_zz),
    .rate_xy   (rate_xy),
    .rate_xz   (rate_xz),
    .rate_yz   (rate_yz)
  );

endmodule

/* bench/esr_rate_checker.sv */
`timescale 1ns / 100ps

module esr_rate_checker #(
  parameter int NODES = esr_pkg::NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [esr_pkg::DATA_W-1:0] deriv_x,
  input  logic signed [esr_pkg::DATA_W-1:0] deriv_y,
  input  logic signed [esr_pkg::DATA_W-1:0] deriv_z,
  input  logic signed [esr_pkg::DATA_W-1:0] vel_x,
  input  logic signed [esr_pkg::DATA_W-1:0] vel_y,
  input  logic signed [esr_pkg::DATA_W-1:0] vel_z,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [esr_pkg::RATE_W-1:0] rate_xx,
  input  logic signed [esr_pkg::RATE_W-1:0] rate_yy,
  input  logic signed [esr_pkg::RATE_W-1:0] rate_zz,
  input  logic signed [esr_pkg::RATE_W-1:0] rate_xy,
  input  logic signed [esr_pkg::RATE_W-1:0] rate_xz,
  input  logic signed [esr_pkg::RATE_W-1:0] rate_yz,
  output int                                mismatches,
  output int                                pending
);

  typedef logic signed [esr_pkg::RATE_W-1:0] rate_t;

  typedef struct packed {
    rate_t xx;
    rate_t yy;
    rate_t zz;
    rate_t xy;
    rate_t xz;
    rate_t yz;
  } rate_set_t;

  rate_t     grad_sum [9];
  int        nodes_in;
  rate_set_t rates_due [$];
  int        err_count;

  // mirrored pair summed one bit wider, then floor halved
  function automatic rate_t half_shear(rate_t a, rate_t b);
    logic signed [esr_pkg::RATE_W:0] s;
    s = $signed({a[esr_pkg::RATE_W-1], a}) + $signed({b[esr_pkg::RATE_W-1], b});
    s = s >>> 1;
    return s[esr_pkg::RATE_W-1:0];
  endfunction

  task automatic clear_gradient();
    for (int k = 0; k < 9; k++) grad_sum[k] = '0;
    nodes_in = 0;
  endtask

  task automatic absorb_node();
    logic signed [esr_pkg::DATA_W-1:0] d [3];
    logic signed [esr_pkg::DATA_W-1:0] v [3];
    logic signed [esr_pkg::PROD_W-1:0] p;
    rate_set_t                         r;
    d = '{deriv_x, deriv_y, deriv_z};
    v = '{vel_x, vel_y, vel_z};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p = d[i] * v[j];
        grad_sum[3*i+j] = grad_sum[3*i+j] +
                          {{(esr_pkg::RATE_W-esr_pkg::PROD_W){p[esr_pkg::PROD_W-1]}}, p};
      end
    end
    nodes_in++;
    if (nodes_in == NODES) begin
      r.xx = grad_sum[0];
      r.yy = grad_sum[4];
      r.zz = grad_sum[8];
      r.xy = half_shear(grad_sum[1], grad_sum[3]);
      r.xz = half_shear(grad_sum[2], grad_sum[6]);
      r.yz = half_shear(grad_sum[5], grad_sum[7]);
      rates_due.push_back(r);
      clear_gradient();
    end
  endtask

  task automatic check_field(string name, rate_t want, rate_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  task automatic check_rates();
    rate_set_t want;
    if (rates_due.size() == 0) begin
      $error("rate result with no request outstanding");
      err_count++;
    end else begin
      want = rates_due.pop_front();
      check_field("rate_xx", want.xx, rate_xx);
      check_field("rate_yy", want.yy, rate_yy);
      check_field("rate_zz", want.zz, rate_zz);
      check_field("rate_xy", want.xy, rate_xy);
      check_field("rate_xz", want.xz, rate_xz);
      check_field("rate_yz", want.yz, rate_yz);
    end
  endtask

  initial begin
    err_count = 0;
    clear_gradient();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_gradient();
      rates_due.delete();
    end else begin
      if (out_valid && !out_stall) check_rates();
      if (in_valid && !in_stall) absorb_node();
    end
    mismatches <= err_count;
    pending    <= rates_due.size();
  end

endmodule

/* bench/tb_element_strain_rate_top.sv */
`timescale 1ns / 100ps

module tb_element_strain_rate_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 304;

  localparam logic signed [esr_pkg::DATA_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [esr_pkg::DATA_W-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [esr_pkg::DATA_W-1:0] S_ONE = 16'sh0001;
  localparam logic signed [esr_pkg::DATA_W-1:0] S_NEG = 16'shffff;
  localparam logic signed [esr_pkg::DATA_W-1:0] S_ZERO = 16'sh0000;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [esr_pkg::DATA_W-1:0] deriv_x = '0;
  logic signed [esr_pkg::DATA_W-1:0] deriv_y = '0;
  logic signed [esr_pkg::DATA_W-1:0] deriv_z = '0;
  logic signed [esr_pkg::DATA_W-1:0] vel_x = '0;
  logic signed [esr_pkg::DATA_W-1:0] vel_y = '0;
  logic signed [esr_pkg::DATA_W-1:0] vel_z = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [esr_pkg::RATE_W-1:0] rate_xx;
  logic signed [esr_pkg::RATE_W-1:0] rate_yy;
  logic signed [esr_pkg::RATE_W-1:0] rate_zz;
  logic signed [esr_pkg::RATE_W-1:0] rate_xy;
  logic signed [esr_pkg::RATE_W-1:0] rate_xz;
  logic signed [esr_pkg::RATE_W-1:0] rate_yz;

  int   mismatches;
  int   pending;
  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;

  element_strain_rate_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .deriv_x  (deriv_x),
    .deriv_y  (deriv_y),
    .deriv_z  (deriv_z),
    .vel_x    (vel_x),
    .vel_y    (vel_y),
    .vel_z    (vel_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rate_xx  (rate_xx),
    .rate_yy  (rate_yy),
    .rate_zz  (rate_zz),
    .rate_xy  (rate_xy),
    .rate_xz  (rate_xz),
    .rate_yz  (rate_yz)
  );

  esr_rate_checker #(
    .NODES(esr_pkg::NODES_DEF)
  ) u_rate_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .deriv_x   (deriv_x),
    .deriv_y   (deriv_y),
    .deriv_z   (deriv_z),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rate_xx   (rate_xx),
    .rate_yy   (rate_yy),
    .rate_zz   (rate_zz),
    .rate_xy   (rate_xy),
    .rate_xz   (rate_xz),
    .rate_yz   (rate_yz),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_element_strain_rate_top: done, errors");
      $finish;
    end
  end

  // result side: random stall, or a long hold-off when asked for one
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // mostly uniform, with the rails and the values around zero mixed in
  function automatic logic signed [esr_pkg::DATA_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return S_MIN;
      1: return S_MAX;
      2: return $urandom_range(1) ? S_ZERO : S_NEG;
      default: return esr_pkg::DATA_W'($urandom());
    endcase
  endfunction

  task automatic send_node(input logic signed [esr_pkg::DATA_W-1:0] dx, dy, dz,
                           input logic signed [esr_pkg::DATA_W-1:0] vx, vy, vz);
    // each idle cycle is drawn on its own
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    deriv_x  <= dx;
    deriv_y  <= dy;
    deriv_z  <= dz;
    vel_x    <= vx;
    vel_y    <= vy;
    vel_z    <= vz;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // full-scale positive products on every term
    for (int n = 0; n < esr_pkg::NODES_DEF; n++) begin
      send_node(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN);
    end
    // alternating rails
    for (int n = 0; n < esr_pkg::NODES_DEF; n++) begin
      if (n % 2 == 1) send_node(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN);
      else            send_node(S_MIN, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX);
    end
    // odd negative shear sums, then zero nodes
    send_node(S_ONE, S_ONE, S_ONE, S_ZERO, S_NEG, S_ZERO);
    send_node(S_ZERO, S_ZERO, S_NEG, S_ONE, S_ZERO, S_ZERO);
    for (int n = 2; n < esr_pkg::NODES_DEF; n++) begin
      send_node(S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          hold_req <= ~hold_req;
        end
        1: begin
          idle_pct = 78;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 78;
        end
        default: begin
          idle_pct = 21;
          stall_pct <= 21;
        end
      endcase
      repeat (PHASE_ITEMS) begin
        send_node(pick_sample(), pick_sample(), pick_sample(),
                  pick_sample(), pick_sample(), pick_sample());
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_element_strain_rate_top: done, clean");
    end else begin
      $display("tb_element_strain_rate_top: done, errors");
    end
    $finish;
  end

endmodule
